### design/zih_pkg.sv
// ----------------------------------------------------------------------------
// zih_pkg
// shared types and constants of the zobrist incremental hash core
// ----------------------------------------------------------------------------
package zih_pkg;

  localparam int NUM_KEYS   = 781;
  localparam int NUM_DRAWS  = 2 * NUM_KEYS;
  localparam int NUM_PIECES = 12;
  localparam int KEY_AW     = $clog2(NUM_KEYS);
  localparam int DRAW_CW    = $clog2(NUM_DRAWS);
  localparam int BB_AW      = $clog2(NUM_PIECES);

  localparam int TURN_KEY        = 64 * 12;
  localparam int CASTLE_KEY_BASE = 64 * 12 + 1;
  localparam int EP_KEY_BASE     = 64 * 12 + 5;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  localparam logic [6:0] EP_NONE = 7'h7f;

  // command codes
  localparam logic [2:0] FN_ADD    = 3'd0;
  localparam logic [2:0] FN_REMOVE = 3'd1;
  localparam logic [2:0] FN_EP     = 3'd2;
  localparam logic [2:0] FN_CASTLE = 3'd3;
  localparam logic [2:0] FN_TURN   = 3'd4;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // key table fill traffic from the generator
  typedef struct packed {
    logic              key_we;
    logic [KEY_AW-1:0] key_addr;
    logic [63:0]       key_data;
    logic              bb_clr;
    logic              busy;
  } fill_t;

endpackage

### design/zobrist_incremental_hash_core.sv
// ----------------------------------------------------------------------------
// zobrist_incremental_hash_core
// incremental zobrist position hash over a chess board held in memory
// ----------------------------------------------------------------------------
// usage
//  - input channel (in_valid / in_ready) carries one board command per beat:
//    add piece, remove piece, set en passant, set castling right, set turn
//  - result channel (out_valid / out_ready) returns one beat per command:
//    the running 64-bit hash after the command and the bad_command flag
//  - after reset the key table is filled by a 32-bit lcg, one draw per
//    cycle: 1562 draws, and in_ready stays low until the fill is done;
//    the bitboard memory is cleared in the same sweep
//  - a command is accepted in ST_IDLE (key and bitboard reads issued),
//    and executed in ST_EXEC (xor into hash, bitboard write back), so no
//    new command is accepted until the last one has executed, set by the
//    read-modify-write of the bitboard memory; out_valid is set at execute
//  - the result sits in an output register; the next command is accepted
//    while it waits, and execution holds only if that register is still full
//  - one command is in flight at a time, so a bitboard write always lands
//    before the next read of the same entry
// ----------------------------------------------------------------------------
module zobrist_incremental_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_piece_kind,
  input  logic [5:0]  in_square_index,
  input  logic signed [6:0] in_ep_target,
  input  logic        in_castle_color,
  input  logic        in_castle_side,
  input  logic        in_castle_allowed,
  input  logic        in_new_turn,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_position_hash,
  output logic        out_bad_command
);
  import zih_pkg::*;

  // control
  state_t st_r;
  state_t st_nxt;
  logic   slot_free;
  logic   exec_fire;
  logic   accept;
  fill_t  fill;

  // command captured at accept
  logic [2:0] func_r;
  logic [3:0] kind_r;
  logic [5:0] sq_r;
  logic [6:0] ep_in_r;
  logic       ccol_r;
  logic       cside_r;
  logic       callow_r;
  logic       turn_r;

  // board scalars
  logic [63:0] hash_r;
  logic [6:0]  ep_r;
  logic [3:0]  castle_r;
  logic        stm_r;

  logic [63:0] hash_nxt;
  logic [6:0]  ep_nxt;
  logic [3:0]  castle_nxt;
  logic        stm_nxt;
  logic        bad_nxt;
  logic        bb_we_x;
  logic [63:0] bb_wdata_x;
  logic [6:0]  ep_tgt;
  logic [1:0]  cidx;

  // output register
  logic        out_valid_r;
  logic [63:0] out_hash_r;
  logic        out_bad_r;

  // memory ports
  logic [KEY_AW-1:0] key_raddr_a;
  logic [KEY_AW-1:0] key_raddr_b;
  logic [63:0]       key_a;
  logic [63:0]       key_b;
  logic [BB_AW-1:0]  bb_raddr;
  logic [63:0]       bb_rdata;
  logic              bb_we;
  logic [BB_AW-1:0]  bb_waddr;
  logic [63:0]       bb_wdata;

  zih_keygen u_keygen (
    .clk   (clk),
    .rst_n (rst_n),
    .fill  (fill)
  );

  // ---------------------------------------------------------------- fsm
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_FILL: if (!fill.busy) st_nxt = ST_IDLE;
      ST_IDLE: if (in_valid)   st_nxt = ST_EXEC;
      ST_EXEC: if (slot_free)  st_nxt = ST_IDLE;
      default: st_nxt = ST_FILL;
    endcase
  end

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    in_ready  = 1'b0;
    exec_fire = 1'b0;
    unique case (st_r)
      ST_FILL: ;
      ST_IDLE: in_ready  = 1'b1;
      ST_EXEC: exec_fire = slot_free;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_FILL;
    end else begin
      st_r <= st_nxt;
    end
  end

  // ---------------------------------------------------------------- read issue
  // key port a: key of the command itself (new en passant column for ep)
  always_comb begin
    case (in_func) inside
      FN_ADD, FN_REMOVE: key_raddr_a = KEY_AW'({in_piece_kind, in_square_index});
      FN_EP:     key_raddr_a = KEY_AW'(EP_KEY_BASE) + KEY_AW'(in_ep_target[2:0]);
      FN_CASTLE: key_raddr_a = KEY_AW'(CASTLE_KEY_BASE) +
                               KEY_AW'({in_castle_color, in_castle_side});
      default:   key_raddr_a = KEY_AW'(TURN_KEY);
    endcase
  end

  // key port b: key of the en passant column being left
  assign key_raddr_b = KEY_AW'(EP_KEY_BASE) + KEY_AW'(ep_r[2:0]);

  // out-of-range piece codes are rejected anyway, keep the read in range
  assign bb_raddr = (in_piece_kind < 4'(NUM_PIECES)) ? BB_AW'(in_piece_kind) : '0;

  zih_key_ram u_key_ram (
    .clk     (clk),
    .we      (fill.key_we),
    .waddr   (fill.key_addr),
    .wdata   (fill.key_data),
    .re      (accept),
    .raddr_a (key_raddr_a),
    .raddr_b (key_raddr_b),
    .rdata_a (key_a),
    .rdata_b (key_b)
  );

  // write port shared by the clearing sweep and the execute write back
  assign bb_we    = fill.bb_clr || (exec_fire && bb_we_x);
  assign bb_waddr = fill.bb_clr ? BB_AW'(fill.key_addr) : BB_AW'(kind_r);
  assign bb_wdata = fill.bb_clr ? 64'd0 : bb_wdata_x;

  zih_bb_ram u_bb_ram (
    .clk   (clk),
    .we    (bb_we),
    .waddr (bb_waddr),
    .wdata (bb_wdata),
    .re    (accept),
    .raddr (bb_raddr),
    .rdata (bb_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_func;
      kind_r   <= in_piece_kind;
      sq_r     <= in_square_index;
      ep_in_r  <= in_ep_target;
      ccol_r   <= in_castle_color;
      cside_r  <= in_castle_side;
      callow_r <= in_castle_allowed;
      turn_r   <= in_new_turn;
    end
  end

  // ---------------------------------------------------------------- execute
  // any negative target means none
  assign ep_tgt = ep_in_r[6] ? EP_NONE : {1'b0, ep_in_r[5:0]};
  assign cidx   = {ccol_r, cside_r};

  always_comb begin
    hash_nxt   = hash_r;
    ep_nxt     = ep_r;
    castle_nxt = castle_r;
    stm_nxt    = stm_r;
    bad_nxt    = 1'b0;
    bb_we_x    = 1'b0;
    bb_wdata_x = bb_rdata ^ (64'd1 << sq_r);
    case (func_r) inside
      FN_ADD, FN_REMOVE: begin
        // a bad piece code, an add onto a set bit or remove of a clear bit is rejected
        if ((kind_r >= 4'(NUM_PIECES)) || (bb_rdata[sq_r] == (func_r == FN_ADD))) begin
          bad_nxt = 1'b1;
        end else begin
          hash_nxt = hash_r ^ key_a;
          bb_we_x  = 1'b1;
        end
      end
      FN_EP: begin
        if (ep_tgt != ep_r) begin
          if (!ep_r[6]) hash_nxt = hash_nxt ^ key_b;
          if (!ep_tgt[6]) hash_nxt = hash_nxt ^ key_a;
          ep_nxt = ep_tgt;
        end
      end
      FN_CASTLE: begin
        if (castle_r[cidx] != callow_r) begin
          castle_nxt[cidx] = callow_r;
          hash_nxt         = hash_r ^ key_a;
        end
      end
      FN_TURN: begin
        if (turn_r != stm_r) begin
          stm_nxt  = turn_r;
          hash_nxt = hash_r ^ key_a;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= '0;
      ep_r     <= EP_NONE;
      castle_r <= '0;
      stm_r    <= 1'b0;
    end else if (exec_fire) begin
      hash_r   <= hash_nxt;
      ep_r     <= ep_nxt;
      castle_r <= castle_nxt;
      stm_r    <= stm_nxt;
    end
  end

  // ---------------------------------------------------------------- result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_hash_r <= hash_nxt;
      out_bad_r  <= bad_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position_hash = out_hash_r;
  assign out_bad_command   = out_bad_r;

  // ---------------------------------------------------------------- checks
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill.busy |-> !in_ready)
    else $error("command accepted while key table still filling");

  a_exec_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid)
    else $error("executed command produced no result beat");

  a_bad_keeps_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && bad_nxt) |=> (out_position_hash == $past(hash_r)))
    else $error("rejected command changed the hash");

  a_ep_encoding: assert property (@(posedge clk) disable iff (!rst_n)
    ep_r[6] |-> (ep_r == EP_NONE))
    else $error("en passant register holds a malformed none code");

endmodule

### design/zih_keygen.sv
// ----------------------------------------------------------------------------
// zih_keygen
// lcg sequencer that fills the key table after reset, one draw per cycle
// ----------------------------------------------------------------------------
module zih_keygen (
  input  logic          clk,
  input  logic          rst_n,
  output zih_pkg::fill_t fill
);
  import zih_pkg::*;

  logic [31:0]        seed_r;
  logic [31:0]        seed_nxt;
  logic [31:0]        hi_r;
  logic [DRAW_CW-1:0] cnt_r;
  logic               busy_r;
  logic               last;

  assign seed_nxt = seed_r * LCG_MUL + LCG_ADD;
  assign last     = (cnt_r == DRAW_CW'(NUM_DRAWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      seed_r <= seed_nxt;
      cnt_r  <= cnt_r + DRAW_CW'(1);
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // even draw is the high word
  always_ff @(posedge clk) begin
    if (busy_r && !cnt_r[0]) begin
      hi_r <= seed_nxt;
    end
  end

  assign fill.key_we   = busy_r & cnt_r[0];
  assign fill.key_addr = cnt_r[DRAW_CW-1:1];
  assign fill.key_data = {hi_r, seed_nxt};
  assign fill.bb_clr   = fill.key_we && (fill.key_addr < KEY_AW'(NUM_PIECES));
  assign fill.busy     = busy_r;

endmodule

### design/zih_key_ram.sv
// ----------------------------------------------------------------------------
// zih_key_ram
// key table, one write port and two registered read ports
// ----------------------------------------------------------------------------
module zih_key_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [zih_pkg::KEY_AW-1:0] waddr,
  input  logic [63:0]               wdata,
  input  logic                      re,
  input  logic [zih_pkg::KEY_AW-1:0] raddr_a,
  input  logic [zih_pkg::KEY_AW-1:0] raddr_b,
  output logic [63:0]               rdata_a,
  output logic [63:0]               rdata_b
);
  import zih_pkg::*;

  logic [63:0] mem [NUM_KEYS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### design/zih_bb_ram.sv
// ----------------------------------------------------------------------------
// zih_bb_ram
// per piece bitboards, one write port and one registered read port
// ----------------------------------------------------------------------------
module zih_bb_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [zih_pkg::BB_AW-1:0] waddr,
  input  logic [63:0]              wdata,
  input  logic                     re,
  input  logic [zih_pkg::BB_AW-1:0] raddr,
  output logic [63:0]              rdata
);
  import zih_pkg::*;

  logic [63:0] mem [NUM_PIECES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
